/* sv/quaternion_rotate_multiply_macros.svh */
// Assertion macros for the quaternion rotate/multiply block.
// Each macro expects clk and arst_n in scope.
`ifndef QUATERNION_ROTATE_MULTIPLY_MACROS_SVH
`define QUATERNION_ROTATE_MULTIPLY_MACROS_SVH

// same-cycle implication, checked out of reset
`define QRM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define QRM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/qrm_pkg.sv */
package qrm_pkg;

	// fraction bits of the Q1.14 rotor
	localparam int FRAC_BITS = 14;

	// operand widths of the Hamilton units
	localparam int P_W    = 19;               // left operand: input a or first product
	localparam int Q_W    = 17;               // right operand: b or conj(a)
	localparam int PROD_W = P_W + Q_W;        // one partial product
	localparam int SUM_W  = PROD_W + 2;       // sum of four partial products
	localparam int RND_W  = SUM_W - FRAC_BITS;

	// component indexes
	localparam int IW = 0;
	localparam int IX = 1;
	localparam int IY = 2;
	localparam int IZ = 3;

	typedef logic signed [P_W-1:0]    p_t;
	typedef logic signed [Q_W-1:0]    q_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic signed [RND_W-1:0]  rnd_t;

	typedef enum logic {
		OP_PRODUCT  = 1'b0,
		OP_ROTATE   = 1'b1
	} op_t;

endpackage

/* sv/qrm_hamilton.sv */
module qrm_hamilton (
	input  logic         clk,
	input  logic         en,
	input  qrm_pkg::p_t  p [4],
	input  qrm_pkg::q_t  q [4],
	output qrm_pkg::rnd_t r [4]
);
	import qrm_pkg::*;

	localparam sum_t ROUND_BIAS = sum_t'(1) <<< (FRAC_BITS - 1);

	prod_t prod_q [4][4];
	sum_t  s      [4];
	sum_t  biased [4];

	// all sixteen partial products, registered
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					prod_q[i][j] <= prod_t'(p[i]) * prod_t'(q[j]);
				end
			end
		end
	end

	// Hamilton sign pattern
	always_comb begin
		s[IW] = sum_t'(prod_q[IW][IW]) - sum_t'(prod_q[IX][IX])
		      - sum_t'(prod_q[IY][IY]) - sum_t'(prod_q[IZ][IZ]);
		s[IX] = sum_t'(prod_q[IW][IX]) + sum_t'(prod_q[IX][IW])
		      + sum_t'(prod_q[IY][IZ]) - sum_t'(prod_q[IZ][IY]);
		s[IY] = sum_t'(prod_q[IW][IY]) - sum_t'(prod_q[IX][IZ])
		      + sum_t'(prod_q[IY][IW]) + sum_t'(prod_q[IZ][IX]);
		s[IZ] = sum_t'(prod_q[IW][IZ]) + sum_t'(prod_q[IX][IY])
		      - sum_t'(prod_q[IY][IX]) + sum_t'(prod_q[IZ][IW]);
	end

	// round half up, then drop the fraction (floor)
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			biased[i] = s[i] + ROUND_BIAS;
			r[i]      = biased[i][SUM_W-1:FRAC_BITS];
		end
	end

endmodule

/* sv/quaternion_rotate_multiply.sv */
// Quaternion product / rotation, fixed point.
//
// Input channel (in_valid / in_stall): opcode, rotor a (signed Q1.14) and
// operand b. opcode 0 returns a*b, opcode 1 returns a*b*conj(a); set b_w to
// zero to rotate a 3-vector. A transfer happens on a rising edge with valid
// high and stall low.
// Output channel (out_valid / out_stall): r_w..r_z at the scale of b, each
// clipped to 16 bits, and saturated set when any component was clipped.
//
// Throughput: one item per cycle while out_stall is low. Pipeline: four
// register stages (products of the first Hamilton pass, its rounded sum,
// products of the second pass, rounded and clipped result); out_valid rises
// once the item is in the last of these, the output register.
// Opcode 0 takes the same path and latency.
// When out_stall is held, the result stays put and stages behind it fill up
// from bubbles first; in_stall rises only once stage one is full and cannot
// move. Nothing is dropped or repeated.
// Reset clears all valid bits; the data registers are not reset.
`include "quaternion_rotate_multiply_macros.svh"

module quaternion_rotate_multiply (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic signed [15:0]  a_w,
	input  logic signed [15:0]  a_x,
	input  logic signed [15:0]  a_y,
	input  logic signed [15:0]  a_z,
	input  logic signed [15:0]  b_w,
	input  logic signed [15:0]  b_x,
	input  logic signed [15:0]  b_y,
	input  logic signed [15:0]  b_z,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  r_w,
	output logic signed [15:0]  r_x,
	output logic signed [15:0]  r_y,
	output logic signed [15:0]  r_z,
	output logic                saturated
);
	import qrm_pkg::*;

	localparam rnd_t CLIP_HI = rnd_t'(32767);
	localparam rnd_t CLIP_LO = rnd_t'(-32768);

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	// side registers
	op_t   op_s1, op_s2, op_s3;
	q_t    ac_s1 [4];
	q_t    ac_s2 [4];
	p_t    r1_s2 [4];
	p_t    r1_s3 [4];
	logic signed [15:0] r_s4 [4];
	logic  sat_s4;

	// unit operands and results
	p_t    p1 [4];
	q_t    q1 [4];
	rnd_t  rnd1 [4];
	rnd_t  rnd2 [4];

	// final select and clip
	rnd_t  fin [4];
	logic signed [15:0] clip [4];
	logic [3:0] clip_hit;

	// a stage moves when empty or when the one ahead moves
	assign en4      = !v_s4 || !out_stall;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// first pass operands: a times b
	always_comb begin
		p1[IW] = p_t'(a_w);
		p1[IX] = p_t'(a_x);
		p1[IY] = p_t'(a_y);
		p1[IZ] = p_t'(a_z);
		q1[IW] = q_t'(b_w);
		q1[IX] = q_t'(b_x);
		q1[IY] = q_t'(b_y);
		q1[IZ] = q_t'(b_z);
	end

	qrm_hamilton u_pass1 (
		.clk (clk),
		.en  (en1),
		.p   (p1),
		.q   (q1),
		.r   (rnd1)
	);

	// stage 1: opcode and conj(a) ride along with the first products
	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1     <= op_t'(opcode);
			ac_s1[IW] <= q_t'(a_w);
			ac_s1[IX] <= -q_t'(a_x);
			ac_s1[IY] <= -q_t'(a_y);
			ac_s1[IZ] <= -q_t'(a_z);
		end
	end

	// stage 2: rounded first product, fits 19 bits without clipping
	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2 <= op_s1;
			for (int i = 0; i < 4; i++) begin
				r1_s2[i] <= rnd1[i][P_W-1:0];
				ac_s2[i] <= ac_s1[i];
			end
		end
	end

	qrm_hamilton u_pass2 (
		.clk (clk),
		.en  (en3),
		.p   (r1_s2),
		.q   (ac_s2),
		.r   (rnd2)
	);

	// stage 3: keep the first product for plain multiplies
	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3 <= op_s2;
			for (int i = 0; i < 4; i++) begin
				r1_s3[i] <= r1_s2[i];
			end
		end
	end

	// pick the result and clip to 16 bits
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			case (op_s3)
				OP_ROTATE:  fin[i] = rnd2[i];
				default:    fin[i] = rnd_t'(r1_s3[i]);
			endcase
			if (fin[i] > CLIP_HI) begin
				clip[i]     = 16'sh7fff;
				clip_hit[i] = 1'b1;
			end else if (fin[i] < CLIP_LO) begin
				clip[i]     = -16'sh8000;
				clip_hit[i] = 1'b1;
			end else begin
				clip[i]     = fin[i][15:0];
				clip_hit[i] = 1'b0;
			end
		end
	end

	// stage 4: output register
	always_ff @(posedge clk) begin
		if (en4) begin
			for (int i = 0; i < 4; i++) begin
				r_s4[i] <= clip[i];
			end
			sat_s4 <= |clip_hit;
		end
	end

	assign out_valid = v_s4;
	assign r_w       = r_s4[IW];
	assign r_x       = r_s4[IX];
	assign r_y       = r_s4[IY];
	assign r_z       = r_s4[IZ];
	assign saturated = sat_s4;

	// pipeline checks
	`QRM_ASSERT_NXT(a_accept_fills_s1, in_valid && !in_stall, v_s1,
		"accepted transfer did not reach stage one")
	`QRM_ASSERT_IMP(a_stall_needs_full, in_stall, v_s1 && v_s2 && v_s3 && v_s4,
		"input stalled while a pipeline stage was empty")
	`QRM_ASSERT_IMP(a_empty_out_no_stall, !out_valid, !in_stall,
		"input stalled with no result waiting")

endmodule
